// ===== rtl/csa_pkg.sv =====
// types and constants shared by the contiguous slot allocator files
`timescale 1ns / 1ps

package csa_pkg;

    localparam int NUM_SLOTS_DEF = 64;

    localparam int OP_W      = 2;
    localparam int POS_W     = 6;
    localparam int SIZE_W    = 7;
    localparam int STATUS_W  = 3;
    localparam int IDX_OUT_W = 6;
    localparam int EXTENT_W  = 7;
    localparam int SLOT_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_RESERVE = 2'd3
    } op_t;

    typedef enum logic [SLOT_W-1:0] {
        SLOT_NEVER    = 2'd0,
        SLOT_RELEASED = 2'd1,
        SLOT_INUSE    = 2'd2
    } slot_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOROOM   = 3'd1,
        ST_BADARG   = 3'd2,
        ST_AFTERREL = 3'd3,
        ST_NOTUSED  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_SCAN  = 3'd1,
        S_WRITE = 3'd2,
        S_DONE  = 3'd3
    } state_t;

endpackage

// ===== rtl/csa_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module csa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/contiguous_slot_allocator_unit.sv =====
// first-fit contiguous slot allocator: top level with slot map sequencer
//
//   channel   handshake       payload
//   request   start / busy    operation, position, size
//   result    done (strobe)   status, slot_index, reused, used_extent
//
// a scan reads one slot per cycle from the slot map ram, then a write phase
// marks one slot per cycle. clear sweeps the whole map.
// after reset the map is swept to never-used, busy high.
// done is a one-cycle strobe; busy stays high until after it.
`timescale 1ns / 1ps

module contiguous_slot_allocator_unit #(
    parameter int NUM_SLOTS = csa_pkg::NUM_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [csa_pkg::OP_W-1:0]       operation,
    input  logic [csa_pkg::POS_W-1:0]      position,
    input  logic [csa_pkg::SIZE_W-1:0]     size,
    output logic                           done,
    output logic [csa_pkg::STATUS_W-1:0]   status,
    output logic [csa_pkg::IDX_OUT_W-1:0]  slot_index,
    output logic                           reused,
    output logic [csa_pkg::EXTENT_W-1:0]   used_extent
);

    import csa_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W = $clog2(NUM_SLOTS + 128) + 1;
    localparam int OUT_W = (CNT_W > EXTENT_W) ? CNT_W : EXTENT_W;
    localparam logic [CMP_W-1:0] NUM_C = CMP_W'(NUM_SLOTS);

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] scan_end_reg, scan_end_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0] mark_reg, mark_next;
    logic [IDX_W-1:0] alt_reg, alt_next;
    logic             flag_reg, flag_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] wr_end_reg, wr_end_next;
    slot_t            wr_val_reg, wr_val_next;
    logic             report_reg, report_next;
    status_t          status_reg, status_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             reused_reg, reused_next;
    logic [CNT_W-1:0] extent_reg, extent_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;

    slot_t            d;
    logic [CNT_W-1:0] k;
    logic [CMP_W-1:0] size_c;
    logic             stop;
    logic             go_write;
    logic             go_done;
    logic [CNT_W-1:0] wr_start_c;
    slot_t            wr_val_c;
    status_t          res_st;
    logic [CNT_W-1:0] res_idx;
    logic             res_reu;
    logic [CNT_W-1:0] wr_end_c;
    logic [OUT_W-1:0] idx_wide;
    logic [OUT_W-1:0] ext_wide;

    csa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_SLOTS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign d      = slot_t'(ram_rdata);
    assign k      = CNT_W'(pend_idx_reg);
    assign size_c = CMP_W'(size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_WRITE;
            rd_ptr_reg   <= '0;
            scan_end_reg <= '0;
            pend_reg     <= 1'b0;
            wr_ptr_reg   <= '0;
            wr_end_reg   <= CNT_W'(NUM_SLOTS);
            wr_val_reg   <= SLOT_NEVER;
            report_reg   <= 1'b0;
            extent_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_ptr_reg   <= rd_ptr_next;
            scan_end_reg <= scan_end_next;
            pend_reg     <= pend_next;
            wr_ptr_reg   <= wr_ptr_next;
            wr_end_reg   <= wr_end_next;
            wr_val_reg   <= wr_val_next;
            report_reg   <= report_next;
            extent_reg   <= extent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        size_reg     <= size_next;
        pend_idx_reg <= pend_idx_next;
        mark_reg     <= mark_next;
        alt_reg      <= alt_next;
        flag_reg     <= flag_next;
        cnt_reg      <= cnt_next;
        status_reg   <= status_next;
        idx_reg      <= idx_next;
        reused_reg   <= reused_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        size_next     = size_reg;
        rd_ptr_next   = rd_ptr_reg;
        scan_end_next = scan_end_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        mark_next     = mark_reg;
        alt_next      = alt_reg;
        flag_next     = flag_reg;
        cnt_next      = cnt_reg;
        wr_ptr_next   = wr_ptr_reg;
        wr_end_next   = wr_end_reg;
        wr_val_next   = wr_val_reg;
        report_next   = report_reg;
        status_next   = status_reg;
        idx_next      = idx_reg;
        reused_next   = reused_reg;
        extent_next   = extent_reg;
        ram_we        = 1'b0;
        ram_waddr     = wr_ptr_reg[IDX_W-1:0];
        ram_wdata     = wr_val_reg;
        stop          = 1'b0;
        go_write      = 1'b0;
        go_done       = 1'b0;
        wr_start_c    = mark_reg;
        wr_val_c      = SLOT_INUSE;
        res_st        = ST_OK;
        res_idx       = '0;
        res_reu       = 1'b0;
        wr_end_c      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next       = op_t'(operation);
                    size_next     = size;
                    rd_ptr_next   = '0;
                    scan_end_next = CNT_W'(NUM_SLOTS);
                    flag_next     = 1'b0;
                    cnt_next      = '0;
                    mark_next     = '0;
                    alt_next      = '0;
                    unique case (op_t'(operation))
                        OP_CLEAR:
                        begin
                            wr_ptr_next = '0;
                            wr_end_next = CNT_W'(NUM_SLOTS);
                            wr_val_next = SLOT_NEVER;
                            report_next = 1'b1;
                            extent_next = '0;
                            status_next = ST_OK;
                            idx_next    = '0;
                            reused_next = 1'b0;
                            state_next  = S_WRITE;
                        end
                        OP_ALLOC, OP_RESERVE:
                        begin
                            if (CMP_W'(size) > NUM_C)
                            begin
                                go_done = 1'b1;
                                res_st  = ST_BADARG;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (size == '0)
                            begin
                                go_done = 1'b1;
                            end
                            else if (CMP_W'(size) > NUM_C
                                     || CMP_W'(position) + CMP_W'(size) > NUM_C)
                            begin
                                go_done = 1'b1;
                                res_st  = ST_BADARG;
                            end
                            else
                            begin
                                rd_ptr_next   = CNT_W'(position);
                                scan_end_next = CNT_W'(CMP_W'(position) + CMP_W'(size));
                                mark_next     = CNT_W'(position);
                                state_next    = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (pend_reg)
                begin
                    unique case (op_reg)
                        OP_ALLOC:
                        begin
                            if (size_reg == '0)
                            begin
                                if (d == SLOT_NEVER)
                                begin
                                    stop    = 1'b1;
                                    go_done = 1'b1;
                                    res_idx = k;
                                end
                                else if (d == SLOT_RELEASED && !flag_reg)
                                begin
                                    flag_next = 1'b1;
                                    alt_next  = pend_idx_reg;
                                end
                            end
                            else if (d == SLOT_INUSE)
                            begin
                                if (CMP_W'(cnt_reg) >= size_c)
                                begin
                                    stop     = 1'b1;
                                    go_write = 1'b1;
                                    res_idx  = mark_reg;
                                    res_reu  = flag_reg;
                                end
                                else
                                begin
                                    cnt_next  = '0;
                                    flag_next = 1'b0;
                                end
                            end
                            else
                            begin
                                if (cnt_reg == '0)
                                begin
                                    mark_next = k;
                                end
                                cnt_next  = cnt_reg + CNT_W'(1);
                                flag_next = flag_reg | (d == SLOT_RELEASED);
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (d != SLOT_INUSE)
                            begin
                                stop    = 1'b1;
                                go_done = 1'b1;
                                res_st  = ST_NOTUSED;
                            end
                        end
                        OP_RESERVE:
                        begin
                            if (!flag_reg)
                            begin
                                if (d == SLOT_NEVER)
                                begin
                                    flag_next = 1'b1;
                                    mark_next = k;
                                    cnt_next  = CNT_W'(1);
                                    if (CMP_W'(pend_idx_reg) + size_c > NUM_C)
                                    begin
                                        stop    = 1'b1;
                                        go_done = 1'b1;
                                        res_st  = ST_NOROOM;
                                    end
                                    else if (size_reg == '0)
                                    begin
                                        stop    = 1'b1;
                                        go_done = 1'b1;
                                        res_idx = k;
                                    end
                                    else if (size_c == CMP_W'(1))
                                    begin
                                        stop       = 1'b1;
                                        go_write   = 1'b1;
                                        wr_start_c = k;
                                        res_idx    = k;
                                    end
                                end
                                else if (d == SLOT_RELEASED)
                                begin
                                    stop    = 1'b1;
                                    go_done = 1'b1;
                                    res_st  = ST_AFTERREL;
                                end
                            end
                            else if (d != SLOT_NEVER)
                            begin
                                stop    = 1'b1;
                                go_done = 1'b1;
                                res_st  = ST_AFTERREL;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + CNT_W'(1);
                                if (CMP_W'(cnt_reg) + CMP_W'(1) == size_c)
                                begin
                                    stop     = 1'b1;
                                    go_write = 1'b1;
                                    res_idx  = mark_reg;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            stop    = 1'b1;
                            go_done = 1'b1;
                        end
                    endcase
                end

                if (!stop && rd_ptr_reg < scan_end_reg)
                begin
                    rd_ptr_next   = rd_ptr_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_ptr_reg[IDX_W-1:0];
                end
                else if (!stop && !pend_reg)
                begin
                    // scan ran to the end of its range
                    unique case (op_reg)
                        OP_ALLOC:
                        begin
                            if (size_reg == '0)
                            begin
                                go_done = 1'b1;
                                if (flag_reg)
                                begin
                                    res_idx = CNT_W'(alt_reg);
                                    res_reu = 1'b1;
                                end
                                else
                                begin
                                    res_st = ST_NOROOM;
                                end
                            end
                            else if (CMP_W'(cnt_reg) >= size_c)
                            begin
                                go_write = 1'b1;
                                res_idx  = mark_reg;
                                res_reu  = flag_reg;
                            end
                            else
                            begin
                                go_done = 1'b1;
                                res_st  = ST_NOROOM;
                            end
                        end
                        OP_RELEASE:
                        begin
                            go_write = 1'b1;
                            wr_val_c = SLOT_RELEASED;
                        end
                        OP_RESERVE:
                        begin
                            if (flag_reg)
                            begin
                                go_write = 1'b1;
                                res_idx  = mark_reg;
                            end
                            else if (size_reg == '0)
                            begin
                                go_done = 1'b1;
                                res_idx = CNT_W'(NUM_SLOTS);
                            end
                            else
                            begin
                                go_done = 1'b1;
                                res_st  = ST_NOROOM;
                            end
                        end
                        OP_CLEAR:
                        begin
                            go_done = 1'b1;
                        end
                    endcase
                end
            end

            S_WRITE:
            begin
                ram_we      = 1'b1;
                wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                if (wr_ptr_reg + CNT_W'(1) == wr_end_reg)
                begin
                    state_next = report_reg ? S_DONE : S_IDLE;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        wr_end_c = CNT_W'(CMP_W'(wr_start_c) + size_c);

        if (go_write)
        begin
            wr_ptr_next = wr_start_c;
            wr_end_next = wr_end_c;
            wr_val_next = wr_val_c;
            report_next = 1'b1;
            if (wr_val_c == SLOT_INUSE && wr_end_c > extent_reg)
            begin
                extent_next = wr_end_c;
            end
            state_next = S_WRITE;
        end
        else if (go_done)
        begin
            state_next = S_DONE;
        end

        if (go_write || go_done)
        begin
            status_next = res_st;
            idx_next    = (res_st == ST_OK) ? res_idx : '0;
            reused_next = (res_st == ST_OK) ? res_reu : 1'b0;
        end
    end

    assign idx_wide = OUT_W'(idx_reg);
    assign ext_wide = OUT_W'(extent_reg);

    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_DONE);
    assign status      = status_reg;
    assign slot_index  = idx_wide[IDX_OUT_W-1:0];
    assign reused      = reused_reg;
    assign used_extent = ext_wide[EXTENT_W-1:0];

endmodule

// ===== rtl/csa_checker.sv =====
// port-level checks for the contiguous slot allocator, bound to the top level
`timescale 1ns / 1ps

module csa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [csa_pkg::OP_W-1:0]       operation,
    input logic                           done,
    input logic [csa_pkg::STATUS_W-1:0]   status,
    input logic [csa_pkg::IDX_OUT_W-1:0]  slot_index,
    input logic                           reused,
    input logic [csa_pkg::EXTENT_W-1:0]   used_extent
);

    import csa_pkg::*;

    // accepted request keeps the unit busy until its result
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted request");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe without busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> slot_index == '0 && !reused)
        else $error("failed request reports slot or reuse");

    a_extent_clear: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation == OP_CLEAR |=> ##1 used_extent == '0)
        else $error("extent not zero after clear");

endmodule

bind contiguous_slot_allocator_unit csa_checker u_csa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .done        (done),
    .status      (status),
    .slot_index  (slot_index),
    .reused      (reused),
    .used_extent (used_extent)
);

// ===== tb/sv/contiguous_slot_allocator_unit_test.sv =====
// self-checking testbench for the contiguous slot allocator unit
`timescale 1ns / 1ps

module contiguous_slot_allocator_unit_test;

    import csa_pkg::*;

    localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_WAIT  = 2 * NUM_SLOTS + 16;

    typedef struct {
        status_t                status;
        logic [IDX_OUT_W-1:0]   slot_index;
        logic                   reused;
        logic [EXTENT_W-1:0]    used_extent;
    } alloc_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [OP_W-1:0]        operation;
    logic [POS_W-1:0]       position;
    logic [SIZE_W-1:0]      size;
    logic                   done;
    logic [STATUS_W-1:0]    status;
    logic [IDX_OUT_W-1:0]   slot_index;
    logic                   reused;
    logic [EXTENT_W-1:0]    used_extent;

    slot_t          slot_shadow [NUM_SLOTS] = '{default: SLOT_NEVER};
    alloc_result_t  pending_results [$];
    int             failures = 0;
    int             cycle_count = 0;
    int             sender_idle_pct = 0;

    contiguous_slot_allocator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .position    (position),
        .size        (size),
        .done        (done),
        .status      (status),
        .slot_index  (slot_index),
        .reused      (reused),
        .used_extent (used_extent)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic alloc_result_t predict_allocation(op_t op, int unsigned pos,
                                                         int unsigned sz);
        alloc_result_t r;
        int unsigned p;
        int unsigned e;
        int unsigned k;
        bit rel;
        bit found;
        bit blocked;
        r.status = ST_OK;
        r.slot_index = '0;
        r.reused = 1'b0;
        r.used_extent = '0;
        found = 1'b0;
        blocked = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                for (k = 0; k < NUM_SLOTS; k++)
                    slot_shadow[k] = SLOT_NEVER;
            end
            OP_ALLOC:
            begin
                if (sz > NUM_SLOTS)
                    r.status = ST_BADARG;
                else if (sz == 0)
                begin
                    for (k = 0; k < NUM_SLOTS && !found; k++)
                        if (slot_shadow[k] == SLOT_NEVER)
                        begin
                            r.slot_index = IDX_OUT_W'(k);
                            found = 1'b1;
                        end
                    for (k = 0; k < NUM_SLOTS && !found; k++)
                        if (slot_shadow[k] == SLOT_RELEASED)
                        begin
                            r.slot_index = IDX_OUT_W'(k);
                            r.reused = 1'b1;
                            found = 1'b1;
                        end
                    if (!found)
                        r.status = ST_NOROOM;
                end
                else
                begin
                    p = 0;
                    while (p < NUM_SLOTS && !found)
                    begin
                        if (slot_shadow[p] == SLOT_INUSE)
                            p++;
                        else
                        begin
                            // walk the whole free run, noting any released slot
                            rel = 1'b0;
                            e = p;
                            while (e < NUM_SLOTS && slot_shadow[e] != SLOT_INUSE)
                            begin
                                if (slot_shadow[e] == SLOT_RELEASED)
                                    rel = 1'b1;
                                e++;
                            end
                            if (e - p >= sz)
                            begin
                                for (k = p; k < p + sz; k++)
                                    slot_shadow[k] = SLOT_INUSE;
                                r.slot_index = IDX_OUT_W'(p);
                                r.reused = rel;
                                found = 1'b1;
                            end
                            else
                                p = e;
                        end
                    end
                    if (!found)
                        r.status = ST_NOROOM;
                end
            end
            OP_RELEASE:
            begin
                if (sz != 0)
                begin
                    if (sz > NUM_SLOTS || pos + sz > NUM_SLOTS)
                        r.status = ST_BADARG;
                    else
                    begin
                        for (k = pos; k < pos + sz; k++)
                            if (slot_shadow[k] != SLOT_INUSE)
                                r.status = ST_NOTUSED;
                        if (r.status == ST_OK)
                            for (k = pos; k < pos + sz; k++)
                                slot_shadow[k] = SLOT_RELEASED;
                    end
                end
            end
            default:
            begin
                if (sz > NUM_SLOTS)
                    r.status = ST_BADARG;
                else
                begin
                    p = 0;
                    while (p < NUM_SLOTS && slot_shadow[p] != SLOT_NEVER && !blocked)
                    begin
                        if (slot_shadow[p] == SLOT_RELEASED)
                            blocked = 1'b1;
                        else
                            p++;
                    end
                    if (blocked)
                        r.status = ST_AFTERREL;
                    else if (p + sz > NUM_SLOTS)
                        r.status = ST_NOROOM;
                    else
                    begin
                        for (k = p; k < p + sz; k++)
                            if (slot_shadow[k] != SLOT_NEVER)
                                r.status = ST_AFTERREL;
                        if (r.status == ST_OK)
                        begin
                            for (k = p; k < p + sz; k++)
                                slot_shadow[k] = SLOT_INUSE;
                            r.slot_index = IDX_OUT_W'(p);
                        end
                    end
                end
            end
        endcase
        if (r.status != ST_OK)
        begin
            r.slot_index = '0;
            r.reused = 1'b0;
        end
        for (k = 0; k < NUM_SLOTS; k++)
            if (slot_shadow[k] != SLOT_NEVER)
                r.used_extent = EXTENT_W'(k + 1);
        return r;
    endfunction

    // start stays high from one request to the next when no idle gap is drawn
    task automatic send_request(input op_t op, input int unsigned pos, input int unsigned sz);
        int gap;
        alloc_result_t want;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(1, 2 * NUM_SLOTS + 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        position  <= POS_W'(pos);
        size      <= SIZE_W'(sz);
        do
            @(posedge clk);
        while (busy !== 1'b0);
        want = predict_allocation(op, pos, sz);
        pending_results.push_back(want);
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_results
        alloc_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending: status %0d slot_index %0d",
                       status, slot_index);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, status);
                    failures++;
                end
                if (slot_index !== want.slot_index)
                begin
                    $error("slot_index expected %0d actual %0d", want.slot_index, slot_index);
                    failures++;
                end
                if (reused !== want.reused)
                begin
                    $error("reused expected %0d actual %0d", want.reused, reused);
                    failures++;
                end
                if (used_extent !== want.used_extent)
                begin
                    $error("used_extent expected %0d actual %0d", want.used_extent,
                           used_extent);
                    failures++;
                end
            end
        end
    end

    task automatic test_directed_cases();
        sender_idle_pct = 0;
        send_request(OP_ALLOC, 0, 0);           // empty map, first never-used
        send_request(OP_RESERVE, 0, 3);
        send_request(OP_ALLOC, 63, 4);
        send_request(OP_RELEASE, 1, 2);
        send_request(OP_RESERVE, 0, 1);         // released slot in the prefix
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, 0, 1);           // lands on a released slot
        send_request(OP_RELEASE, 0, 0);
        send_request(OP_RELEASE, 60, 5);        // runs past the end
        send_request(OP_RELEASE, 10, 1);        // slot not in use
        send_request(OP_ALLOC, 0, 65);
        send_request(OP_RESERVE, 0, 127);
        send_request(OP_RELEASE, 63, 127);
        send_request(OP_ALLOC, 0, 64);          // no fit
        send_request(OP_CLEAR, 42, 99);
        send_request(OP_ALLOC, 0, 2);
        send_request(OP_ALLOC, 0, 1);
        send_request(OP_ALLOC, 0, 2);
        send_request(OP_RELEASE, 2, 1);
        send_request(OP_ALLOC, 0, 2);           // short run skipped
        send_request(OP_CLEAR, 0, 0);
        send_request(OP_ALLOC, 0, 64);
        send_request(OP_ALLOC, 0, 0);           // full map
        send_request(OP_RESERVE, 0, 0);         // full map, index wraps
        send_request(OP_RESERVE, 0, 1);
        send_request(OP_RELEASE, 0, 64);
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, 5, 1);
        send_request(OP_RELEASE, 63, 1);
        send_request(OP_CLEAR, 63, 127);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct);
        int unsigned roll;
        int unsigned pos;
        int unsigned sz;
        int unsigned k;
        int unsigned run_len;
        bit found;
        op_t op;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
                op = OP_CLEAR;
            else if (roll < 45)
                op = OP_ALLOC;
            else if (roll < 72)
                op = OP_RELEASE;
            else
                op = OP_RESERVE;
            roll = $urandom_range(99);
            if (roll < 60)
                sz = $urandom_range(0, 6);
            else if (roll < 90)
                sz = $urandom_range(7, 32);
            else if (roll < 97)
                sz = $urandom_range(33, NUM_SLOTS);
            else
                sz = $urandom_range(NUM_SLOTS + 1, 127);
            pos = $urandom_range(NUM_SLOTS - 1);
            // most releases target a run that is really in use
            if (op == OP_RELEASE && $urandom_range(99) < 80)
            begin
                found = 1'b0;
                for (k = 0; k < NUM_SLOTS && !found; k++)
                    if (slot_shadow[(pos + k) % NUM_SLOTS] == SLOT_INUSE)
                    begin
                        pos = (pos + k) % NUM_SLOTS;
                        found = 1'b1;
                    end
                if (found)
                begin
                    run_len = 0;
                    while (pos + run_len < NUM_SLOTS && slot_shadow[pos + run_len] == SLOT_INUSE)
                        run_len++;
                    sz = $urandom_range(1, run_len);
                end
            end
            send_request(op, pos, sz);
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        operation <= OP_CLEAR;
        position  <= '0;
        size      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_traffic(590, 25);
        test_random_traffic(590, 81);
        test_random_traffic(590, 0);
        wait_results_drained();
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/csa_pkg.sv
rtl/csa_ram.sv
rtl/contiguous_slot_allocator_unit.sv
rtl/csa_checker.sv
tb/sv/contiguous_slot_allocator_unit_test.sv
